>>> hw/rtl/positional_ordered_list_macros.svh
// assertion macros for the positional ordered list
// used by the top level only; needs no package
`ifndef POSITIONAL_ORDERED_LIST_MACROS_SVH
`define POSITIONAL_ORDERED_LIST_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define POL_ASSERT_NOW(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define POL_ASSERT_NEXT(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error(msg);

`endif

>>> hw/rtl/pol_pkg.sv
// shared types and constants for the positional ordered list
// no dependencies; used by pol_core and positional_ordered_list
`default_nettype none

package pol_pkg;

   localparam int DATA_W = 32;
   localparam int POS_W  = 6;
   localparam int LEN_W  = 7;

   typedef enum logic [1:0] {
      ACT_APPEND = 2'd0,
      ACT_INSERT = 2'd1,
      ACT_DELETE = 2'd2,
      ACT_DUMP   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2,
      STATUS_EMPTY = 2'd3
   } status_type;

   typedef enum logic [6:0] {
      ST_IDLE      = 7'b0000001,
      ST_SHIFT     = 7'b0000010,
      ST_PLACE     = 7'b0000100,
      ST_ACK       = 7'b0001000,
      ST_DUMP_RD   = 7'b0010000,
      ST_DUMP_DATA = 7'b0100000,
      ST_SPARE     = 7'b1000000
   } state_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] element;
      logic                     is_element;
      logic [LEN_W-1:0]         list_length;
      status_type               status;
      logic                     last;
   } result_type;

endpackage

`default_nettype wire

>>> hw/rtl/pol_core.sv
// list sequencer: element memory, count and the shift/dump state machine
// depends on pol_pkg
`default_nettype none

module pol_core #(
   parameter int DEPTH = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire pol_pkg::action_type                 req_action,
   input  wire logic signed [pol_pkg::DATA_W-1:0]   req_value,
   input  wire logic [pol_pkg::POS_W-1:0]           req_position,
   output logic                                     res_valid,
   input  wire logic                                res_ready,
   output pol_pkg::result_type                      res
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   // element storage, one write and one registered read per cycle
   logic [pol_pkg::DATA_W-1:0] mem_ff [DEPTH];
   logic [pol_pkg::DATA_W-1:0] rd_data_ff;
   logic [AW-1:0]              rd_addr;
   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   logic [pol_pkg::DATA_W-1:0] wr_data;

   pol_pkg::state_type  state_ff, state_in;
   pol_pkg::status_type status_ff, status_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       mv_left_ff, mv_left_in;
   logic [AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0]       idx_ff, idx_in;
   logic [AW-1:0]       pos_ff, pos_in;
   logic [AW-1:0]       prev_waddr_ff, prev_waddr_in;
   logic                prev_valid_ff, prev_valid_in;
   logic                is_ins_ff, is_ins_in;
   logic [pol_pkg::DATA_W-1:0] value_ff, value_in;

   logic [pol_pkg::LEN_W-1:0] count_ext;
   logic [pol_pkg::LEN_W-1:0] pos_ext;
   logic [CW-1:0]             idx_next;
   logic                      is_full;
   logic                      is_empty;

   assign count_ext = pol_pkg::LEN_W'(count_ff);
   assign pos_ext   = pol_pkg::LEN_W'(req_position);
   assign idx_next  = CW'(idx_ff) + CW'(1);
   assign is_full   = (count_ff == CW'(DEPTH));
   assign is_empty  = (count_ff == '0);
   assign req_ready = (state_ff == pol_pkg::ST_IDLE);

   // memory ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      status_in     = status_ff;
      count_in      = count_ff;
      mv_left_in    = mv_left_ff;
      rd_ptr_in     = rd_ptr_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      prev_waddr_in = prev_waddr_ff;
      prev_valid_in = 1'b0;
      is_ins_in     = is_ins_ff;
      value_in      = value_ff;
      rd_addr       = rd_ptr_ff;
      wr_en         = 1'b0;
      wr_addr       = prev_waddr_ff;
      wr_data       = rd_data_ff;
      res_valid     = 1'b0;
      res.element     = '0;
      res.is_element  = 1'b0;
      res.list_length = count_ext;
      res.status      = status_ff;
      res.last        = 1'b1;

      case (state_ff)
         pol_pkg::ST_IDLE: begin
            if (req_valid) begin
               value_in  = req_value;
               pos_in    = req_position[AW-1:0];
               status_in = pol_pkg::STATUS_OK;
               state_in  = pol_pkg::ST_ACK;
               case (req_action)
                  pol_pkg::ACT_APPEND: begin
                     if (is_full) begin
                        status_in = pol_pkg::STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[AW-1:0];
                        wr_data  = req_value;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  pol_pkg::ACT_INSERT: begin
                     if (is_full) begin
                        status_in = pol_pkg::STATUS_FULL;
                     end else if (pos_ext > count_ext) begin
                        status_in = pol_pkg::STATUS_RANGE;
                     end else begin
                        // move count-position entries up, from the top down
                        is_ins_in  = 1'b1;
                        mv_left_in = CW'(count_ext - pos_ext);
                        rd_ptr_in  = AW'(count_ff - CW'(1));
                        state_in   = pol_pkg::ST_SHIFT;
                     end
                  end
                  pol_pkg::ACT_DELETE: begin
                     if (is_empty) begin
                        status_in = pol_pkg::STATUS_EMPTY;
                     end else if (pos_ext >= count_ext) begin
                        status_in = pol_pkg::STATUS_RANGE;
                     end else begin
                        // move entries above position down by one
                        is_ins_in  = 1'b0;
                        mv_left_in = CW'(count_ext - pos_ext - pol_pkg::LEN_W'(1));
                        rd_ptr_in  = AW'(pos_ext + pol_pkg::LEN_W'(1));
                        state_in   = pol_pkg::ST_SHIFT;
                     end
                  end
                  pol_pkg::ACT_DUMP: begin
                     if (is_empty) begin
                        status_in = pol_pkg::STATUS_EMPTY;
                     end else begin
                        idx_in   = '0;
                        state_in = pol_pkg::ST_DUMP_RD;
                     end
                  end
                  default: begin
                     state_in = pol_pkg::ST_ACK;
                  end
               endcase
            end
         end

         pol_pkg::ST_SHIFT: begin
            // write back the entry read in the previous cycle
            if (prev_valid_ff) begin
               wr_en = 1'b1;
            end
            if (mv_left_ff != '0) begin
               rd_addr       = rd_ptr_ff;
               prev_valid_in = 1'b1;
               prev_waddr_in = is_ins_ff ? rd_ptr_ff + AW'(1) : rd_ptr_ff - AW'(1);
               rd_ptr_in     = is_ins_ff ? rd_ptr_ff - AW'(1) : rd_ptr_ff + AW'(1);
               mv_left_in    = mv_left_ff - CW'(1);
            end else begin
               state_in = pol_pkg::ST_PLACE;
            end
         end

         pol_pkg::ST_PLACE: begin
            if (is_ins_ff) begin
               wr_en    = 1'b1;
               wr_addr  = pos_ff;
               wr_data  = value_ff;
               count_in = count_ff + CW'(1);
            end else begin
               count_in = count_ff - CW'(1);
            end
            state_in = pol_pkg::ST_ACK;
         end

         pol_pkg::ST_ACK: begin
            if (res_ready) begin
               res_valid = 1'b1;
               state_in  = pol_pkg::ST_IDLE;
            end
         end

         pol_pkg::ST_DUMP_RD: begin
            // issue a read only when the result register can take the beat
            if (res_ready) begin
               rd_addr  = idx_ff;
               state_in = pol_pkg::ST_DUMP_DATA;
            end
         end

         pol_pkg::ST_DUMP_DATA: begin
            res_valid      = 1'b1;
            res.element    = rd_data_ff;
            res.is_element = 1'b1;
            res.status     = pol_pkg::STATUS_OK;
            res.last       = (idx_next == count_ff);
            idx_in         = AW'(idx_next);
            state_in       = (idx_next == count_ff) ? pol_pkg::ST_IDLE
                                                    : pol_pkg::ST_DUMP_RD;
         end

         default: begin
            state_in = pol_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pol_pkg::ST_IDLE;
         count_ff      <= '0;
         prev_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         prev_valid_ff <= prev_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      status_ff     <= status_in;
      mv_left_ff    <= mv_left_in;
      rd_ptr_ff     <= rd_ptr_in;
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      prev_waddr_ff <= prev_waddr_in;
      is_ins_ff     <= is_ins_in;
      value_ff      <= value_in;
   end

endmodule

`default_nettype wire

>>> hw/rtl/positional_ordered_list.sv
// Positional ordered list: up to DEPTH signed 32-bit values in list order.
// Request beats (req_) carry an action in req_tuser: append, insert at a
// position, delete at a position, or dump. Append, insert and delete give one
// response beat with the new length and a status; dump gives one beat per
// stored element in order, tlast on the final one, or a single beat with
// status empty when the list holds nothing.
// Sequencing: append and every rejected action go from acceptance through
// the acknowledge state to the response register; insert and delete first
// step through the shift state for every moved element and then the place
// state, since every moved element passes once through the single read
// and single write port of the element memory; dump reads each element
// from memory and then loads it into the response register. A new request
// is taken once the previous one has its last beat in the response
// register.
// Reset clears the length to zero; memory contents are not cleared, since
// only entries below the length are ever read, so no clearing pass is run.
// When the receiver holds rsp_tready low, the response register holds its
// beat and the sequencer waits; nothing is dropped.
// depends on pol_pkg, pol_core and positional_ordered_list_macros.svh
`default_nettype none

`include "positional_ordered_list_macros.svh"

module positional_ordered_list #(
   parameter int DEPTH = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,  // value [31:0], position [37:32], zero pad
   input  wire logic [1:0]  req_tuser,  // action [1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,  // element [31:0], list_length [38:32],
                                        // status [40:39], zero pad
   output logic             rsp_tuser,  // is_element [0]
   output logic             rsp_tlast
);

   logic                       core_res_valid;
   logic                       core_res_ready;
   pol_pkg::result_type        core_res;
   logic signed [pol_pkg::DATA_W-1:0] req_value;
   logic [pol_pkg::POS_W-1:0]  req_position;
   pol_pkg::action_type        req_action;

   logic                out_valid_ff, out_valid_in;
   pol_pkg::result_type out_data_ff;

   // unpack the request beat
   assign req_value    = signed'(req_tdata[31:0]);
   assign req_position = req_tdata[37:32];
   assign req_action   = pol_pkg::action_type'(req_tuser);

   pol_core #(
      .DEPTH (DEPTH)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_action   (req_action),
      .req_value    (req_value),
      .req_position (req_position),
      .res_valid    (core_res_valid),
      .res_ready    (core_res_ready),
      .res          (core_res)
   );

   // response register: free when empty or being drained this cycle
   assign core_res_ready = !out_valid_ff || rsp_tready;

   always_comb begin
      if (core_res_valid) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (core_res_valid) begin
         out_data_ff <= core_res;
      end
   end

   // pack the response beat
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_data_ff.status, out_data_ff.list_length,
                        out_data_ff.element};
   assign rsp_tuser  = out_data_ff.is_element;
   assign rsp_tlast  = out_data_ff.last;

   // checks
   `POL_ASSERT_NOW(a_res_fits, clock, reset, core_res_valid,
                   !out_valid_ff || rsp_tready, "result produced while output busy")
   `POL_ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready,
                    !req_tready, "request accepted while a request was in flight")
   `POL_ASSERT_NOW(a_len_bound, clock, reset, rsp_tvalid,
                   rsp_tdata[38:32] <= pol_pkg::LEN_W'(DEPTH), "length above depth")
   `POL_ASSERT_NOW(a_elem_ok, clock, reset, rsp_tvalid && rsp_tuser,
                   rsp_tdata[40:39] == pol_pkg::STATUS_OK, "dumped element with bad status")

endmodule

`default_nettype wire
